@@ rtl/aewc_pkg.sv @@
`default_nettype none

package aewc_pkg;

	localparam int DIV_CNT_W = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 1'b1;

	localparam logic MODE_SEND = 1'b0;
	localparam logic MODE_ACK = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd600;
	localparam logic [15:0] FLOOR_RESET = 16'd10;
	localparam logic [15:0] WINDOW_RESET_INT = 16'd100;

	typedef struct packed {
		logic        mode;
		logic        sent_on_timeout;
		logic [31:0] acked_send_time;
		logic [31:0] ack_arrival_time;
	} in_word_t;

	typedef struct packed {
		logic [15:0] window_datagrams;
		logic        window_grew;
	} out_word_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] nbits;
	} div_ctl_t;

endpackage

`default_nettype wire

@@ rtl/aewc_serial_div.sv @@
`default_nettype none

module aewc_serial_div
	import aewc_pkg::*;
#(
	parameter int DVD_W = 65,
	parameter int DVS_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_ctl_t         ctl,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVD_W-1:0]      quotient
);

	// Restoring division, one quotient bit per cycle, dividend taken MSB first.
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W:0]       trial;
	logic [DVS_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff = trial - {1'b0, dvs_q};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/aimd_ewma_window_controller_core.sv @@
// Send events and acks that do not grow the window go straight to the emit state, which loads
// the result word into the output register; a new word is taken only once that result is emitted.
// A growing ack with a nonnegative EWMA runs up to two bit-serial divisions in one shared divider
// and skips the second if the first saturates or the window is zero; with a negative EWMA it runs
// one division, or none when the window is zero. A full output register adds its stall.
// Reset is asynchronous and active low and restores the window, EWMA, history and registers.
`default_nettype none

module aimd_ewma_window_controller_core
	import aewc_pkg::*;
#(
	parameter int WINDOW_FRAC_BITS = 16,
	parameter int EWMA_FRAC_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_word_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_word_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	localparam int EW_W = 34 + EWMA_FRAC_BITS;
	localparam int SUM_W = EW_W + 2;
	localparam int Q1_W = 33 + WINDOW_FRAC_BITS;
	localparam int DW = Q1_W + WINDOW_FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EW1 = 3'd1;
	localparam logic [2:0] ST_EW2 = 3'd2;
	localparam logic [2:0] ST_F = 3'd3;
	localparam logic [2:0] ST_DIV1 = 3'd4;
	localparam logic [2:0] ST_DIV2 = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]              state_q;
	logic [15:0]             timeout_q;
	logic [15:0]             floor_q;
	logic [31:0]             window_q;
	logic signed [EW_W-1:0]  ewma_q;
	logic [31:0]             prev_rtt_q;
	logic [31:0]             prev_snd_q;
	logic [31:0]             prev_arr_q;
	logic                    first_q;
	logic                    grew_q;
	logic signed [32:0]      change_q;
	logic signed [SUM_W-1:0] tmp3_q;
	logic                    out_valid_q;
	out_word_t               out_data_q;

	logic [31:0]             rtt;
	logic                    same_ts;
	logic                    below_floor;
	logic                    grow_ok;
	logic [33:0]             win_x3;
	logic [31:0]             win_dec;
	logic signed [SUM_W-1:0] ewma_sum;
	logic signed [EW_W-1:0]  ewma_next;
	logic [15:0]             t_eff;
	logic [Q1_W+EWMA_FRAC_BITS-1:0] n_cat;
	logic [Q1_W-1:0]         n1;
	logic [Q1_W-1:0]         q1;
	logic                    q1_sat;
	logic [Q1_W-1:0]         f_q1;
	logic [Q1_W-1:0]         f_one;
	logic [Q1_W-1:0]         f_sel;
	logic                    inc_big;
	logic [32:0]             sum33;
	logic [31:0]             grown;
	logic [31:0]             whole32;
	logic                    emit_go;

	div_ctl_t                div_ctl;
	logic [DW-1:0]           div_dvd;
	logic [31:0]             div_dvs;
	logic                    div_done;
	logic [DW-1:0]           div_quo;

	aewc_serial_div #(
		.DVD_W(DW),
		.DVS_W(32)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.done(div_done),
		.quotient(div_quo)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign rtt = in_data.ack_arrival_time - in_data.acked_send_time;
	assign same_ts = (in_data.acked_send_time == prev_snd_q) &&
		(in_data.ack_arrival_time == prev_arr_q);
	assign below_floor = (window_q >> WINDOW_FRAC_BITS) < {16'b0, floor_q};
	assign grow_ok = !same_ts && !below_floor;

	assign win_x3 = {2'b0, window_q} + {1'b0, window_q, 1'b0};
	assign win_dec = win_x3[33:2];

	assign ewma_sum = tmp3_q + (SUM_W'(change_q) <<< EWMA_FRAC_BITS);
	assign ewma_next = EW_W'(ewma_sum >>> 2);

	assign t_eff = (timeout_q == 16'd0) ? 16'd1 : timeout_q;

	// Growth factor minus one: ewma scaled to the window fraction, then divided by the timeout.
	assign n_cat = {ewma_q[EW_W-2:0], {WINDOW_FRAC_BITS{1'b0}}};
	assign n1 = n_cat[EWMA_FRAC_BITS +: Q1_W];

	assign q1 = div_quo[Q1_W-1:0];
	assign q1_sat = q1[Q1_W-1];
	assign f_one = Q1_W'(1) << WINDOW_FRAC_BITS;
	assign f_q1 = q1 + f_one;
	assign f_sel = (state_q == ST_DIV1) ? f_q1 : f_one;

	assign inc_big = |div_quo[DW-1:32];
	assign sum33 = {1'b0, window_q} + {1'b0, div_quo[31:0]};
	assign grown = (inc_big || sum33[32]) ? '1 : sum33[31:0];

	assign whole32 = window_q >> WINDOW_FRAC_BITS;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		div_ctl = '0;
		div_dvd = {f_sel, {WINDOW_FRAC_BITS{1'b0}}};
		div_dvs = window_q;
		unique case (state_q)
			ST_F: begin
				if (!ewma_q[EW_W-1]) begin
					div_ctl.start = 1'b1;
					div_ctl.nbits = DIV_CNT_W'(Q1_W);
					div_dvd = {n1, {WINDOW_FRAC_BITS{1'b0}}};
					div_dvs = {16'b0, t_eff};
				end else if (window_q != '0) begin
					div_ctl.start = 1'b1;
					div_ctl.nbits = DIV_CNT_W'(DW);
				end
			end
			ST_DIV1: begin
				if (div_done && !q1_sat && window_q != '0) begin
					div_ctl.start = 1'b1;
					div_ctl.nbits = DIV_CNT_W'(DW);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			timeout_q <= TIMEOUT_RESET;
			floor_q <= FLOOR_RESET;
			window_q <= 32'(WINDOW_RESET_INT) << WINDOW_FRAC_BITS;
			ewma_q <= EW_W'(1) <<< EWMA_FRAC_BITS;
			prev_rtt_q <= '0;
			prev_snd_q <= '0;
			prev_arr_q <= '0;
			first_q <= 1'b1;
			grew_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_FLOOR: floor_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						grew_q <= 1'b0;
						state_q <= ST_EMIT;
						if (in_data.mode == MODE_SEND) begin
							if (in_data.sent_on_timeout) begin
								window_q <= win_dec;
							end
						end else if (first_q || grow_ok) begin
							prev_rtt_q <= rtt;
							prev_snd_q <= in_data.acked_send_time;
							prev_arr_q <= in_data.ack_arrival_time;
							first_q <= 1'b0;
							if (!first_q) begin
								grew_q <= 1'b1;
								state_q <= ST_EW1;
							end
						end
					end
				end
				ST_EW1: state_q <= ST_EW2;
				ST_EW2: begin
					ewma_q <= ewma_next;
					state_q <= ST_F;
				end
				ST_F: begin
					if (!ewma_q[EW_W-1]) begin
						state_q <= ST_DIV1;
					end else if (window_q == '0) begin
						window_q <= '1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						if (q1_sat || window_q == '0) begin
							window_q <= '1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DIV2;
						end
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						window_q <= grown;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			change_q <= $signed({1'b0, prev_rtt_q}) - $signed({1'b0, rtt});
		end
		if (state_q == ST_EW1) begin
			tmp3_q <= SUM_W'(ewma_q) + (SUM_W'(ewma_q) <<< 1);
		end
		if (emit_go) begin
			out_data_q.window_datagrams <= (|whole32[31:16]) ? 16'hFFFF : whole32[15:0];
			out_data_q.window_grew <= grew_q;
		end
	end

`ifndef SYNTHESIS
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished outside a division state");

	a_growth_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV2 && div_done) |=> window_q >= $past(window_q))
		else $error("growth step reduced the window");

	a_send_direct: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.mode == MODE_SEND) |=> state_q == ST_EMIT)
		else $error("send word did not go straight to the result");

	a_grew_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && grew_q) |-> !first_q)
		else $error("growth reported before the first ack was recorded");
`endif

endmodule

`default_nettype wire

@@ verif/aimd_ewma_window_controller_core_test.sv @@
`default_nettype none

module aimd_ewma_window_controller_core_test;
	import aewc_pkg::*;

	localparam int WFRAC = 16;
	localparam int EFRAC = 8;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_WORDS = 270;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TIMEOUT;
	logic [15:0] cfg_data = '0;

	aimd_ewma_window_controller_core #(
		.WINDOW_FRAC_BITS(WFRAC),
		.EWMA_FRAC_BITS(EFRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the controller state and registers.
	logic [15:0] timeout_reg = TIMEOUT_RESET;
	logic [15:0] floor_reg = FLOOR_RESET;
	logic [31:0] win_fix = 32'(WINDOW_RESET_INT) << WFRAC;
	longint ewma_acc = longint'(1) <<< EFRAC;
	logic [31:0] prev_rtt = '0;
	logic [31:0] prev_snd = '0;
	logic [31:0] prev_arr = '0;
	logic first_ack = 1'b1;

	in_word_t pending_words[$];
	out_word_t window_expect[$];
	in_word_t last_ack_word = '0;
	logic [31:0] clock_ms = '0;
	logic hold_off = 1'b0;
	int queued = 0;
	int accepted = 0;
	int faults = 0;
	int gap_left = 0;
	int burst_left = 1;
	logic [15:0] rx_cycle = '0;
	int n_acks = 0;
	int n_grew = 0;
	int n_cuts = 0;
	int n_sat = 0;
	int n_zero = 0;

	function automatic logic [31:0] grown_window(logic [63:0] f, logic [31:0] w);
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] inc;
		logic [63:0] sum;
		if (w == 0)
			return '1;
		q = f / w;
		r = f % w;
		if (q >= 64'h1_0000_0000)
			return '1;
		inc = (q << WFRAC) + ((r << WFRAC) / w);
		sum = {32'b0, w} + inc;
		if (sum > 64'hFFFF_FFFF)
			return '1;
		return sum[31:0];
	endfunction

	function automatic logic apply_ack(logic [31:0] snd, logic [31:0] arr);
		logic [31:0] rtt;
		longint change;
		logic [63:0] e;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] f;
		rtt = arr - snd;
		if (first_ack) begin
			prev_rtt = rtt;
			prev_snd = snd;
			prev_arr = arr;
			first_ack = 1'b0;
			return 1'b0;
		end
		if (snd == prev_snd && arr == prev_arr)
			return 1'b0;
		if ({32'b0, win_fix} < (64'(floor_reg) << WFRAC))
			return 1'b0;
		change = longint'({32'b0, prev_rtt}) - longint'({32'b0, rtt});
		ewma_acc = (3 * ewma_acc + change * (64'sd1 <<< EFRAC)) >>> 2;
		if (win_fix == 0)
			n_zero++;
		if (ewma_acc >= 0) begin
			e = ewma_acc;
			t = (timeout_reg == 0) ? 64'd1 : 64'(timeout_reg);
			d = t << EFRAC;
			q = e / d;
			r = e % d;
			if (q >= 64'h1_0000_0000) begin
				win_fix = '1;
			end else begin
				f = ((q + 1) << WFRAC) + ((r << WFRAC) / d);
				win_fix = grown_window(f, win_fix);
			end
		end else begin
			win_fix = grown_window(64'd1 << WFRAC, win_fix);
		end
		prev_rtt = rtt;
		prev_snd = snd;
		prev_arr = arr;
		return 1'b1;
	endfunction

	function automatic void advance_window(in_word_t w);
		out_word_t res;
		res.window_grew = 1'b0;
		if (w.mode == MODE_SEND) begin
			if (w.sent_on_timeout) begin
				win_fix = 32'((64'(win_fix) * 3) / 4);
				n_cuts++;
			end
		end else begin
			n_acks++;
			res.window_grew = apply_ack(w.acked_send_time, w.ack_arrival_time);
			if (res.window_grew) begin
				n_grew++;
				if (win_fix == '1)
					n_sat++;
			end
		end
		res.window_datagrams = win_fix[31:16];
		window_expect.push_back(res);
	endfunction

	function automatic void flag_mismatch(string what, out_word_t want, out_word_t got);
		faults++;
		if (faults <= 10)
			$display("%s: expected window %0d grew %0b, got window %0d grew %0b",
				what, want.window_datagrams, want.window_grew,
				got.window_datagrams, got.window_grew);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_window(in_data);
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					in_data <= pending_words.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 15) == 0) ?
							$urandom_range(20, 160) : $urandom_range(0, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		logic take;
		out_word_t want;
		if (out_valid && out_ready) begin
			if (window_expect.size() == 0) begin
				want = '0;
				flag_mismatch("result with nothing expected", want, out_data);
			end else begin
				want = window_expect.pop_front();
				if (out_data.window_datagrams !== want.window_datagrams
						|| out_data.window_grew !== want.window_grew)
					flag_mismatch("result mismatch", want, out_data);
			end
		end
		rx_cycle <= rx_cycle + 1'b1;
		case (rx_cycle[8:7])
			2'd0: take = 1'b1;
			2'd1: take = 1'($urandom_range(0, 1));
			2'd2: take = ($urandom_range(0, 9) == 0);
			default: take = (rx_cycle % 3 == 0);
		endcase
		out_ready <= take && !hold_off && arst_n;
	end

	function automatic void push_word(logic mode, logic sot, logic [31:0] snd, logic [31:0] arr);
		in_word_t w;
		w.mode = mode;
		w.sent_on_timeout = sot;
		w.acked_send_time = snd;
		w.ack_arrival_time = arr;
		if (mode == MODE_ACK)
			last_ack_word = w;
		pending_words.push_back(w);
		queued++;
	endfunction

	task automatic add_traffic(int count);
		int target;
		int kind;
		int len;
		int trend;
		logic [31:0] base;
		logic [31:0] rtt;
		target = queued + count;
		while (queued < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = $urandom_range(4, 30);
				trend = $urandom_range(0, 2);
				base = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(1, 3000);
				if ($urandom_range(0, 9) == 0)
					clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 200);
				for (int i = 0; i < len; i++) begin
					clock_ms += $urandom_range(1, 60);
					case (trend)
						0: rtt = base + $urandom_range(0, 20);
						1: rtt = base - i * $urandom_range(1, 50);
						default: rtt = base + i * $urandom_range(1, 50);
					endcase
					push_word(MODE_ACK, 1'($urandom_range(0, 1)), clock_ms, clock_ms + rtt);
					if ($urandom_range(0, 7) == 0) begin
						pending_words.push_back(last_ack_word);
						queued++;
					end
					if ($urandom_range(0, 5) == 0)
						push_word(MODE_SEND, $urandom_range(0, 3) == 0, $urandom, $urandom);
				end
			end else if (kind < 70) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 90) : $urandom_range(2, 12);
				for (int i = 0; i < len; i++)
					push_word(MODE_SEND, 1'b1, $urandom, $urandom);
			end else if (kind < 90) begin
				push_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom);
			end else begin
				pending_words.push_back(last_ack_word);
				queued++;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMEOUT: timeout_reg = val;
			REG_FLOOR: floor_reg = val;
		endcase
	endtask

	task automatic drain();
		while (accepted != queued || window_expect.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic hold_receiver();
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	initial begin
		clock_ms = $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(MODE_SEND, 1'b0, 32'h0, 32'h0);
		push_word(MODE_SEND, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(MODE_ACK, 1'b1, 32'd1000, 32'd1100);
		push_word(MODE_ACK, 1'b0, 32'd1000, 32'd1100);
		push_word(MODE_ACK, 1'b0, 32'd2000, 32'd2050);
		push_word(MODE_ACK, 1'b0, 32'd3000, 32'd3300);
		push_word(MODE_ACK, 1'b0, 32'hFFFF_FFF0, 32'h10);
		push_word(MODE_ACK, 1'b0, 32'h0, 32'hFFFF_FFFF);
		push_word(MODE_ACK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(MODE_ACK, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_word(MODE_ACK, 1'b0, 32'hFFFF_FFFF, 32'h0);
		push_word(MODE_SEND, 1'b0, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
		add_traffic(PHASE_WORDS - 20);
		drain();

		write_reg(REG_TIMEOUT, 16'd1);
		write_reg(REG_FLOOR, 16'd0);
		push_word(MODE_ACK, 1'b0, 32'h0, 32'hFFFF_FFFF);
		push_word(MODE_ACK, 1'b0, 32'd5, 32'd5);
		push_word(MODE_ACK, 1'b0, 32'd6, 32'd6);
		push_word(MODE_SEND, 1'b1, 32'h0, 32'h0);
		add_traffic(PHASE_WORDS);
		hold_receiver();
		drain();

		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_FLOOR, 16'hFFFF);
		add_traffic(PHASE_WORDS);
		drain();

		write_reg(REG_TIMEOUT, 16'd0);
		write_reg(REG_FLOOR, 16'd0);
		add_traffic(PHASE_WORDS);
		hold_receiver();
		drain();

		write_reg(REG_TIMEOUT, 16'($urandom_range(1, 65535)));
		write_reg(REG_FLOOR, 16'($urandom_range(0, 150)));
		add_traffic(PHASE_WORDS);
		drain();

		$display("Checked %0d words: %0d acks, %0d growth steps, %0d timeout cuts.",
			accepted, n_acks, n_grew, n_cuts);
		$display("Growth hit the window ceiling %0d times and started from zero %0d times.",
			n_sat, n_zero);
		if (faults == 0)
			$display("aimd_ewma_window_controller_core_test: done, clean");
		else
			$display("aimd_ewma_window_controller_core_test: done, errors");
		$finish;
	end

	initial begin
		#30000000;
		$display("aimd_ewma_window_controller_core_test: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
